// File: src/scd_pkg.sv
// shared types, constants and weight table for strip charge deposition
package scd_pkg;

  // default configuration of the strip store
  localparam int STRIP_COUNT_DEF = 512;
  localparam int STRIP_PITCH_DEF = 50;

  // field widths
  localparam int CMD_W      = 2;
  localparam int POS_W      = 16;
  localparam int CHARGE_W   = 4;
  localparam int RIDX_W     = 9;
  localparam int EPU_W      = 24;
  localparam int MAXPOS_W   = 15;
  localparam int SUM_W      = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // command codes
  localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_PER_UNIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POSITION    = 2'd1;

  // register reset values
  localparam logic [EPU_W-1:0]    EPU_RESET    = 24'd65536;
  localparam logic [MAXPOS_W-1:0] MAXPOS_RESET = 15'd25600;

  // arithmetic widths
  localparam int MUL_AW   = 33;
  localparam int MUL_BW   = 32;
  localparam int MUL_PW   = MUL_AW + MUL_BW;
  localparam int ROOT_W   = 32;
  localparam int SQ_OP_W  = 2 * ROOT_W;
  localparam int LEN_W    = 32;
  localparam int E_W      = 49;
  localparam int W_W      = 17;
  localparam int DVS_W    = 16;
  localparam int NEIGH    = 11;
  localparam int HALF     = 5;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // sharing weights in Q1.16, centre strip at index five
  function automatic logic [W_W-1:0] share_weight(input logic [3:0] k);
    logic [W_W-1:0] w;
    case (k)
      4'd0, 4'd10: w = 17'd2294;
      4'd1, 4'd9:  w = 17'd2949;
      4'd2, 4'd8:  w = 17'd6226;
      4'd3, 4'd7:  w = 17'd7537;
      4'd4, 4'd6:  w = 17'd24904;
      4'd5:        w = 17'd65536;
      default:     w = 17'd0;
    endcase
    return w;
  endfunction

endpackage

// File: src/scd_if.sv
// request, result and register write channels
interface scd_in_if import scd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           command;
  logic signed [POS_W-1:0]    x_start;
  logic signed [POS_W-1:0]    y_start;
  logic signed [POS_W-1:0]    x_end;
  logic signed [POS_W-1:0]    y_end;
  logic [CHARGE_W-1:0]        charge;
  logic [RIDX_W-1:0]          read_index;

  modport source (output valid, command, x_start, y_start, x_end, y_end, charge,
                  read_index, input ready);
  modport sink   (input valid, command, x_start, y_start, x_end, y_end, charge,
                  read_index, output ready);
endinterface

interface scd_out_if import scd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RIDX_W-1:0] strip_number;
  logic [SUM_W-1:0]  strip_energy;
  logic              saturated;

  modport source (output valid, strip_number, strip_energy, saturated, input ready);
  modport sink   (input valid, strip_number, strip_energy, saturated, output ready);
endinterface

interface scd_cfg_if import scd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/scd_mul.sv
// shared multiplier with registered product
module scd_mul import scd_pkg::*; (
  input  logic              clk_i,
  input  logic [MUL_AW-1:0] a_i,
  input  logic [MUL_BW-1:0] b_i,
  output logic [MUL_PW-1:0] p_o
);

  logic [MUL_PW-1:0] p_q;

  // product is registered and lands in the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_q <= MUL_PW'(a_i) * MUL_PW'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: src/scd_sqrt.sv
// bit-pair integer square root, one result bit per cycle
module scd_sqrt import scd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SQ_OP_W-1:0] operand_i,
  output logic               busy_o,
  output logic [ROOT_W-1:0]  root_o
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 3;

  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [SQ_OP_W-1:0] op_q, op_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [REM_W-1:0]   r;
  logic [REM_W-1:0]   trial;

  // one digit step
  always_comb begin
    r      = {rem_q[REM_W-3:0], op_q[SQ_OP_W-1 -: 2]};
    trial  = REM_W'({root_q, 2'b01});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    op_d   = op_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      op_d   = operand_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      op_d = {op_q[SQ_OP_W-3:0], 2'b00};
      if (r >= trial) begin
        rem_d  = r - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = r;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

// File: src/scd_div.sv
// restoring divider, one quotient bit per cycle
module scd_div import scd_pkg::*; #(
  parameter int DW = 43
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW-1:0]    dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DW-1:0]    quot_o
);

  localparam int CNT_W = $clog2(DW);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    quot_q, quot_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   r;

  // shift in one dividend bit, trial subtract
  always_comb begin
    r      = {rem_q, quot_q[DW-1]};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (r >= {1'b0, dvs_q}) begin
        rem_d  = DVS_W'(r - {1'b0, dvs_q});
        quot_d = {quot_q[DW-2:0], 1'b1};
      end else begin
        rem_d  = r[DVS_W-1:0];
        quot_d = {quot_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// File: src/strip_charge_deposition.sv
// top level: sequencer, strip store and shared arithmetic units
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    command, x_start, y_start, x_end, y_end, charge, read_index
//  out_o    out  valid/ready    strip_number, strip_energy, saturated
//  cfg_i    in   valid/ready    index, data (always ready)
//
// read: store read, then result, waiting while a held result sits on out_o; clear: zeroes every strip.
// deposit: setup (squares, 32-step root; the start strip comes from a
// reciprocal multiply while the root runs), then per crossed strip the length divide
// and, per neighbour inside the store, a read, two partial products and a write.
// after reset a clearing pass over the whole store runs before the first request.
// in_i is ready only while the sequencer is idle; a held result blocks only the next read.
module strip_charge_deposition import scd_pkg::*; #(
  parameter int STRIP_COUNT = STRIP_COUNT_DEF,
  parameter int STRIP_PITCH = STRIP_PITCH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  scd_in_if.sink    in_i,
  scd_out_if.source out_o,
  scd_cfg_if.sink   cfg_i
);

  localparam int AW    = $clog2(STRIP_COUNT);
  localparam int PW    = $clog2(STRIP_PITCH + 1);
  localparam int DIV_W = PW + ROOT_W;
  localparam int ST_W  = 5;
  localparam int XW    = MAXPOS_W;
  localparam int MW    = SUM_W + 1;
  localparam int CW    = 51;

  // reciprocal of the pitch, exact for every position below 2^XW
  localparam int PITCH_SH  = XW + $clog2(STRIP_PITCH);
  localparam int PITCH_RCP = ((1 << PITCH_SH) + STRIP_PITCH - 1) / STRIP_PITCH;

  localparam logic [XW:0]    PITCH_X = (XW + 1)'(STRIP_PITCH);
  localparam logic [AW-1:0]  LAST_A  = AW'(STRIP_COUNT - 1);

  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_CLR   = 5'd1;
  localparam logic [ST_W-1:0] S_RD    = 5'd2;
  localparam logic [ST_W-1:0] S_RDOUT = 5'd3;
  localparam logic [ST_W-1:0] S_SQ1   = 5'd4;
  localparam logic [ST_W-1:0] S_SQ2   = 5'd5;
  localparam logic [ST_W-1:0] S_SQ3   = 5'd6;
  localparam logic [ST_W-1:0] S_EPQ   = 5'd7;
  localparam logic [ST_W-1:0] S_PREP  = 5'd8;
  localparam logic [ST_W-1:0] S_PMUL  = 5'd9;
  localparam logic [ST_W-1:0] S_PDIV  = 5'd10;
  localparam logic [ST_W-1:0] S_PDIVW = 5'd11;
  localparam logic [ST_W-1:0] S_EMUL  = 5'd12;
  localparam logic [ST_W-1:0] S_ESET  = 5'd13;
  localparam logic [ST_W-1:0] S_NCHK  = 5'd14;
  localparam logic [ST_W-1:0] S_NLO   = 5'd15;
  localparam logic [ST_W-1:0] S_NADD  = 5'd16;
  localparam logic [ST_W-1:0] S_CHQ   = 5'd17;
  localparam logic [ST_W-1:0] S_NBQ   = 5'd18;

  // configuration registers
  logic [EPU_W-1:0]    epu_q;
  logic [MAXPOS_W-1:0] maxpos_q;

  // sequencer and datapath registers
  logic [ST_W-1:0]   state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [POS_W-1:0]  adx_q, adx_d;
  logic [POS_W-1:0]  ady_q, ady_d;
  logic [XW-1:0]     lo_q, lo_d;
  logic [XW-1:0]     hi_q, hi_d;
  logic [7:0]        q2_q, q2_d;
  logic [32:0]       sq_q, sq_d;
  logic [31:0]       epq_q, epq_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [XW-1:0]     ch_q, ch_d;
  logic [XW-1:0]     pos_q, pos_d;
  logic [XW-1:0]     nb_q, nb_d;
  logic [E_W-1:0]    e_q, e_d;
  logic [3:0]        k_q, k_d;
  logic [49:0]       chi_q, chi_d;
  logic [RIDX_W-1:0] ridx_q, ridx_d;
  logic              rok_q, rok_d;

  // result register
  logic              out_vld_q, out_vld_d;
  logic [RIDX_W-1:0] out_num_q, out_num_d;
  logic [SUM_W-1:0]  out_sum_q, out_sum_d;
  logic              out_sat_q, out_sat_d;

  // store
  logic [MW-1:0] mem_q [STRIP_COUNT];
  logic [MW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] wdata;

  // shared units
  logic [MUL_AW-1:0]  mul_a;
  logic [MUL_BW-1:0]  mul_b;
  logic [MUL_PW-1:0]  mul_p;
  logic               sqrt_start, sqrt_busy;
  logic [SQ_OP_W-1:0] sqrt_op;
  logic [ROOT_W-1:0]  sqrt_root;
  logic               div_start, div_busy;
  logic [DIV_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [DIV_W-1:0]   div_quot;

  // request decode
  logic signed [POS_W:0] x0, x1, y0, y1, dx, dy, lo_s, hi_s, lo_c, hi_c, maxpos_s;
  logic                  in_ready, accept, empty;

  // neighbour address and update
  logic signed [XW+1:0]  nidx;
  logic                  nin;
  logic [W_W-1:0]        wgt;
  logic [CW-1:0]         csum, ssum;
  logic                  sat_hit;
  logic [XW:0]           nb_first, nb_next;

  scd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  scd_sqrt u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .operand_i (sqrt_op),
    .busy_o    (sqrt_busy),
    .root_o    (sqrt_root)
  );

  scd_div #(.DW(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  // configuration writes, taken at any time
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epu_q    <= EPU_RESET;
      maxpos_q <= MAXPOS_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == REG_ENERGY_PER_UNIT) begin
        epu_q <= cfg_i.data;
      end else if (cfg_i.index == REG_MAX_POSITION) begin
        maxpos_q <= cfg_i.data[MAXPOS_W-1:0];
      end
    end
  end

  // track span: order, clamp, reject empty
  always_comb begin
    x0       = {in_i.x_start[POS_W-1], in_i.x_start};
    x1       = {in_i.x_end[POS_W-1], in_i.x_end};
    y0       = {in_i.y_start[POS_W-1], in_i.y_start};
    y1       = {in_i.y_end[POS_W-1], in_i.y_end};
    dx       = x1 - x0;
    dy       = y1 - y0;
    lo_s     = (x0 < x1) ? x0 : x1;
    hi_s     = (x0 < x1) ? x1 : x0;
    maxpos_s = $signed({2'b00, maxpos_q});
    lo_c     = (lo_s < 0) ? '0 : lo_s;
    hi_c     = (hi_s > maxpos_s) ? maxpos_s : hi_s;
    empty    = (lo_c >= hi_c) || (dx == '0);
  end

  assign in_ready   = (state_q == S_IDLE);
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // neighbour strip of the current piece
  assign nidx = $signed({2'b00, ch_q}) + $signed({{(XW - 2){1'b0}}, k_q})
              - (XW + 2)'(HALF);
  assign nin  = !nidx[XW+1] && (nidx < (XW + 2)'(STRIP_COUNT));
  assign wgt  = share_weight(k_q);

  // saturating accumulate of one share
  assign csum    = CW'(chi_q) + CW'(mul_p[32:16]);
  assign ssum    = CW'(rdata_q[SUM_W-1:0]) + csum;
  assign sat_hit = ssum >= CW'(SUM_MAX);

  // piece boundaries: first one is (start strip + 1) * pitch from the multiplier
  assign nb_first = mul_p[XW:0];
  assign nb_next  = (XW + 1)'(nb_q) + PITCH_X;

  // sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    adx_d      = adx_q;
    ady_d      = ady_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    q2_d       = q2_q;
    sq_d       = sq_q;
    epq_d      = epq_q;
    root_d     = root_q;
    ch_d       = ch_q;
    pos_d      = pos_q;
    nb_d       = nb_q;
    e_d        = e_q;
    k_d        = k_q;
    chi_d      = chi_q;
    ridx_d     = ridx_q;
    rok_d      = rok_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_num_d  = out_num_q;
    out_sum_d  = out_sum_q;
    out_sat_d  = out_sat_q;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    sqrt_op    = {SQ_OP_W'(sq_q) + SQ_OP_W'(mul_p[31:0])} << 30;
    div_start  = 1'b0;
    div_dvd    = mul_p[DIV_W-1:0];
    div_dvs    = adx_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    waddr      = nidx[AW-1:0];
    raddr      = nidx[AW-1:0];
    wdata      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          adx_d = dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
          ady_d = dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
          lo_d  = lo_c[XW-1:0];
          hi_d  = hi_c[XW-1:0];
          q2_d  = 8'(in_i.charge) * 8'(in_i.charge);
          ridx_d = in_i.read_index;
          rok_d  = 32'(in_i.read_index) < STRIP_COUNT;
          case (in_i.command)
            CMD_DEPOSIT: state_d = empty ? S_IDLE : S_SQ1;
            CMD_READ:    state_d = S_RD;
            CMD_CLEAR: begin
              clr_d   = '0;
              state_d = S_CLR;
            end
            default:     state_d = S_IDLE;
          endcase
        end
      end

      // zero one entry a cycle
      S_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_q;
        wdata  = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == LAST_A) begin
          state_d = S_IDLE;
        end
      end

      S_RD: begin
        mem_re  = rok_q;
        raddr   = AW'(ridx_q);
        state_d = S_RDOUT;
      end

      S_RDOUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_num_d = ridx_q;
          out_sum_d = rok_q ? rdata_q[SUM_W-1:0] : '0;
          out_sat_d = rok_q && rdata_q[SUM_W];
          state_d   = S_IDLE;
        end
      end

      // squares of the spans, then root and charge scale
      S_SQ1: begin
        mul_a   = MUL_AW'(adx_q);
        mul_b   = MUL_BW'(adx_q);
        state_d = S_SQ2;
      end

      S_SQ2: begin
        sq_d    = mul_p[32:0];
        mul_a   = MUL_AW'(ady_q);
        mul_b   = MUL_BW'(ady_q);
        state_d = S_SQ3;
      end

      S_SQ3: begin
        sqrt_start = 1'b1;
        mul_a      = MUL_AW'(epu_q);
        mul_b      = MUL_BW'(q2_q);
        state_d    = S_EPQ;
      end

      // strip of the span start by reciprocal multiply
      S_EPQ: begin
        epq_d   = mul_p[31:0];
        mul_a   = MUL_AW'(lo_q);
        mul_b   = MUL_BW'(PITCH_RCP);
        state_d = S_CHQ;
      end

      S_CHQ: begin
        ch_d    = mul_p[PITCH_SH +: XW];
        mul_a   = MUL_AW'(mul_p[PITCH_SH +: XW]) + MUL_AW'(1);
        mul_b   = MUL_BW'(STRIP_PITCH);
        state_d = S_NBQ;
      end

      S_NBQ: begin
        nb_d    = (nb_first > (XW + 1)'(hi_q)) ? hi_q : nb_first[XW-1:0];
        state_d = S_PREP;
      end

      S_PREP: begin
        if (!sqrt_busy) begin
          pos_d   = lo_q;
          root_d  = sqrt_root;
          state_d = S_PMUL;
        end
      end

      // piece length = piece * root / |dx|
      S_PMUL: begin
        mul_a   = MUL_AW'(nb_q - pos_q);
        mul_b   = root_q;
        state_d = S_PDIV;
      end

      S_PDIV: begin
        div_start = 1'b1;
        state_d   = S_PDIVW;
      end

      S_PDIVW: begin
        if (!div_busy) begin
          state_d = S_EMUL;
        end
      end

      S_EMUL: begin
        mul_a   = MUL_AW'(epq_q);
        mul_b   = div_quot[LEN_W-1:0];
        state_d = S_ESET;
      end

      S_ESET: begin
        e_d     = mul_p[E_W+14:15];
        k_d     = '0;
        state_d = S_NCHK;
      end

      // neighbour loop: read, two partial products, accumulate
      S_NCHK: begin
        if (nin) begin
          mem_re  = 1'b1;
          mul_a   = MUL_AW'(e_q[E_W-1:16]);
          mul_b   = MUL_BW'(wgt);
          state_d = S_NLO;
        end else if (k_q == 4'(NEIGH - 1)) begin
          if (nb_q == hi_q) begin
            state_d = S_IDLE;
          end else begin
            pos_d   = nb_q;
            ch_d    = ch_q + 1'b1;
            nb_d    = (nb_next > (XW + 1)'(hi_q)) ? hi_q : nb_next[XW-1:0];
            state_d = S_PMUL;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end

      S_NLO: begin
        chi_d   = mul_p[49:0];
        mul_a   = MUL_AW'(e_q[15:0]);
        mul_b   = MUL_BW'(wgt);
        state_d = S_NADD;
      end

      S_NADD: begin
        mem_we = 1'b1;
        wdata  = sat_hit ? {1'b1, SUM_MAX} : {rdata_q[SUM_W], ssum[SUM_W-1:0]};
        if (k_q == 4'(NEIGH - 1)) begin
          if (nb_q == hi_q) begin
            state_d = S_IDLE;
          end else begin
            pos_d   = nb_q;
            ch_d    = ch_q + 1'b1;
            nb_d    = (nb_next > (XW + 1)'(hi_q)) ? hi_q : nb_next[XW-1:0];
            state_d = S_PMUL;
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_NCHK;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    adx_q     <= adx_d;
    ady_q     <= ady_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    q2_q      <= q2_d;
    sq_q      <= sq_d;
    epq_q     <= epq_d;
    root_q    <= root_d;
    ch_q      <= ch_d;
    pos_q     <= pos_d;
    nb_q      <= nb_d;
    e_q       <= e_d;
    k_q       <= k_d;
    chi_q     <= chi_d;
    ridx_q    <= ridx_d;
    rok_q     <= rok_d;
    out_num_q <= out_num_d;
    out_sum_q <= out_sum_d;
    out_sat_q <= out_sat_d;
  end

  // strip store: saturation flag over the sum
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.strip_number = out_num_q;
  assign out_o.strip_energy = out_sum_q;
  assign out_o.saturated    = out_sat_q;

  // checks
  a_clr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !in_i.ready)
    else $error("request taken during store sweep");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_sqrt_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_busy)
    else $error("root unit restarted while busy");

  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NADD) |-> nin)
    else $error("neighbour write outside the store");

  a_rd_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RDOUT) && (!out_vld_q || out_o.ready)) |=> out_vld_q)
    else $error("read result not presented");

endmodule
